// ----- rtl/cdp_pkg.sv -----
// shared types, codes and constants for the capability document parser
package cdp_pkg;

	// width of the saturating document byte counter
	localparam int LENGTH_COUNTER_BITS = 16;
	localparam int MAX_LEN_BITS = 16;
	localparam int CMP_BITS = (LENGTH_COUNTER_BITS > MAX_LEN_BITS) ?
		LENGTH_COUNTER_BITS : MAX_LEN_BITS;
	localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_RESET = 16'd4096;

	// parse phases
	localparam logic [3:0] PH_VERSION  = 4'd0;
	localparam logic [3:0] PH_PMIN     = 4'd1;
	localparam logic [3:0] PH_NSCOUNT  = 4'd9;
	localparam logic [3:0] PH_NSLEN    = 4'd10;
	localparam logic [3:0] PH_NSBYTE   = 4'd11;
	localparam logic [3:0] PH_OPTCOUNT = 4'd12;
	localparam logic [3:0] PH_OPTHDR   = 4'd13;
	localparam logic [3:0] PH_OPTVAL   = 4'd14;
	localparam logic [3:0] PH_DONE     = 4'd15;

	localparam logic [7:0] DOC_VERSION = 8'd1;
	// last byte index of an option header (key, length low, length high)
	localparam logic [2:0] OPT_HDR_LAST = 3'd2;

	// field ids with special handling
	localparam logic [3:0] FID_SECURITY = 4'd7;
	localparam logic [3:0] FID_NSCOUNT  = 4'd8;
	localparam logic [3:0] FID_OPTCOUNT = 4'd9;

	// result kinds
	localparam logic [1:0] KIND_FIELD  = 2'd0;
	localparam logic [1:0] KIND_NSLEN  = 2'd1;
	localparam logic [1:0] KIND_NSBYTE = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_BADVER = 3'd1;
	localparam logic [2:0] ST_TRUNC  = 3'd2;
	localparam logic [2:0] ST_TRAIL  = 3'd3;
	localparam logic [2:0] ST_LONG   = 3'd4;

	// one result item plus its valid flag
	typedef struct packed {
		logic        vld;
		logic [1:0]  result_kind;
		logic [3:0]  field_id;
		logic [63:0] field_value;
		logic [7:0]  namespace_number;
		logic        end_of_document;
		logic [2:0]  status;
	} res_t;

	// index of the final byte of each header field
	function automatic logic [2:0] field_last(input logic [3:0] id);
		logic [2:0] r;
		begin
			case (id)
				4'd2, 4'd7, 4'd9: r = 3'd1;
				4'd3:             r = 3'd3;
				4'd4:             r = 3'd7;
				default:          r = 3'd0;
			endcase
			return r;
		end
	endfunction

endpackage

// ----- rtl/cdp_in_if.sv -----
// input channel: one document byte per item
interface cdp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/cdp_out_if.sv -----
// output channel: one parse result per item
interface cdp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [3:0]  field_id;
	logic [63:0] field_value;
	logic [7:0]  namespace_number;
	logic        end_of_document;
	logic [2:0]  status;

	modport source (output valid, output result_kind, output field_id,
		output field_value, output namespace_number, output end_of_document,
		output status, input ready);
	modport sink (input valid, input result_kind, input field_id,
		input field_value, input namespace_number, input end_of_document,
		input status, output ready);
endinterface

// ----- rtl/cdp_parse.sv -----
// parse state registers and the per-byte next-state and result logic
module cdp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output cdp_pkg::res_t       result
);

	localparam int LB = cdp_pkg::LENGTH_COUNTER_BITS;
	localparam int CW = cdp_pkg::CMP_BITS;
	localparam logic [LB-1:0] CNT_SAT = {LB{1'b1}};

	logic [15:0]   max_len_q;
	logic [3:0]    phase_q, phase_n;
	logic [2:0]    bif_q, bif_n;
	logic [63:0]   acc_q, acc_n;
	logic [LB-1:0] cnt_q, cnt_n;
	logic [7:0]    ns_left_q, ns_left_n;
	logic [7:0]    ns_ctr_q, ns_ctr_n;
	logic [15:0]   bytes_left_q, bytes_left_n;
	logic [15:0]   opt_left_q, opt_left_n;
	logic [2:0]    err_q, err_n;

	logic [63:0]   acc_or;
	logic [3:0]    fid;
	logic [7:0]    ns_dec;
	logic [15:0]   bl_dec;
	logic [15:0]   opt_dec;
	logic [15:0]   hdr_len;
	logic          emit;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= cdp_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	assign acc_or  = acc_q | ({56'd0, data_byte} << {bif_q, 3'b000});
	assign fid     = (phase_q == cdp_pkg::PH_OPTCOUNT) ? cdp_pkg::FID_OPTCOUNT :
		(phase_q - cdp_pkg::PH_PMIN);
	assign ns_dec  = ns_left_q - 8'd1;
	assign bl_dec  = bytes_left_q - 16'd1;
	assign opt_dec = opt_left_q - 16'd1;
	assign hdr_len = (bif_q == 3'd1) ? {8'd0, data_byte} :
		((bif_q == 3'd2) ? (acc_q[15:0] | {data_byte, 8'd0}) : acc_q[15:0]);

	// next state and result for one byte
	always_comb begin
		phase_n      = phase_q;
		bif_n        = bif_q;
		acc_n        = acc_q;
		ns_left_n    = ns_left_q;
		ns_ctr_n     = ns_ctr_q;
		bytes_left_n = bytes_left_q;
		opt_left_n   = opt_left_q;
		err_n        = err_q;
		emit         = 1'b0;
		result       = '0;
		result.result_kind = cdp_pkg::KIND_STATUS;

		// saturating byte count and length limit
		if (cnt_q == CNT_SAT) begin
			cnt_n = CNT_SAT;
			err_n = cdp_pkg::ST_LONG;
		end else begin
			cnt_n = cnt_q + 1'b1;
			if (CW'(cnt_n) > CW'(max_len_q)) begin
				err_n = cdp_pkg::ST_LONG;
			end
		end

		if (err_n == cdp_pkg::ST_OK) begin
			case (phase_q)
				cdp_pkg::PH_VERSION: begin
					if (data_byte != cdp_pkg::DOC_VERSION) begin
						err_n = cdp_pkg::ST_BADVER;
					end else begin
						phase_n = cdp_pkg::PH_PMIN;
					end
				end
				4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8,
				cdp_pkg::PH_NSCOUNT, cdp_pkg::PH_OPTCOUNT: begin
					acc_n = acc_or;
					bif_n = bif_q + 3'd1;
					if (bif_q >= cdp_pkg::field_last(fid)) begin
						emit = 1'b1;
						result.result_kind = cdp_pkg::KIND_FIELD;
						result.field_id    = fid;
						result.field_value = acc_or;
						acc_n = '0;
						bif_n = '0;
						if (fid <= cdp_pkg::FID_SECURITY) begin
							phase_n = phase_q + 4'd1;
						end else if (fid == cdp_pkg::FID_NSCOUNT) begin
							ns_left_n = acc_or[7:0];
							ns_ctr_n  = '0;
							phase_n   = (acc_or[7:0] != 8'd0) ? cdp_pkg::PH_NSLEN :
								cdp_pkg::PH_OPTCOUNT;
						end else begin
							opt_left_n = acc_or[15:0];
							phase_n    = (acc_or[15:0] != 16'd0) ? cdp_pkg::PH_OPTHDR :
								cdp_pkg::PH_DONE;
						end
					end
				end
				cdp_pkg::PH_NSLEN, cdp_pkg::PH_NSBYTE: begin
					emit = 1'b1;
					result.result_kind = (phase_q == cdp_pkg::PH_NSLEN) ?
						cdp_pkg::KIND_NSLEN : cdp_pkg::KIND_NSBYTE;
					result.field_value      = {56'd0, data_byte};
					result.namespace_number = ns_ctr_q;
					if (phase_q == cdp_pkg::PH_NSLEN) begin
						bytes_left_n = {8'd0, data_byte};
						phase_n      = cdp_pkg::PH_NSBYTE;
					end else begin
						bytes_left_n = bl_dec;
					end
					// namespace complete
					if ((phase_q == cdp_pkg::PH_NSLEN && data_byte == 8'd0) ||
						(phase_q == cdp_pkg::PH_NSBYTE && bl_dec == 16'd0)) begin
						ns_ctr_n  = ns_ctr_q + 8'd1;
						ns_left_n = ns_dec;
						phase_n   = (ns_dec != 8'd0) ? cdp_pkg::PH_NSLEN :
							cdp_pkg::PH_OPTCOUNT;
					end
				end
				cdp_pkg::PH_OPTHDR: begin
					acc_n = {48'd0, hdr_len};
					bif_n = bif_q + 3'd1;
					if (bif_q >= cdp_pkg::OPT_HDR_LAST) begin
						bytes_left_n = hdr_len;
						acc_n = '0;
						bif_n = '0;
						if (hdr_len == 16'd0) begin
							opt_left_n = opt_dec;
							phase_n    = (opt_dec != 16'd0) ? cdp_pkg::PH_OPTHDR :
								cdp_pkg::PH_DONE;
						end else begin
							phase_n = cdp_pkg::PH_OPTVAL;
						end
					end
				end
				cdp_pkg::PH_OPTVAL: begin
					bytes_left_n = bl_dec;
					if (bl_dec == 16'd0) begin
						opt_left_n = opt_dec;
						phase_n    = (opt_dec != 16'd0) ? cdp_pkg::PH_OPTHDR :
							cdp_pkg::PH_DONE;
					end
				end
				default: begin
					err_n = cdp_pkg::ST_TRAIL;
				end
			endcase
		end

		result.vld = emit | last_byte;

		// end of document: report status and start over
		if (last_byte) begin
			result.end_of_document = 1'b1;
			if (err_n != cdp_pkg::ST_OK) begin
				result.status = err_n;
			end else if (phase_n != cdp_pkg::PH_DONE) begin
				result.status = cdp_pkg::ST_TRUNC;
			end else begin
				result.status = cdp_pkg::ST_OK;
			end
			phase_n      = cdp_pkg::PH_VERSION;
			bif_n        = '0;
			acc_n        = '0;
			cnt_n        = '0;
			ns_left_n    = '0;
			ns_ctr_n     = '0;
			bytes_left_n = '0;
			opt_left_n   = '0;
			err_n        = cdp_pkg::ST_OK;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cdp_pkg::PH_VERSION;
			bif_q        <= '0;
			acc_q        <= '0;
			cnt_q        <= '0;
			ns_left_q    <= '0;
			ns_ctr_q     <= '0;
			bytes_left_q <= '0;
			opt_left_q   <= '0;
			err_q        <= cdp_pkg::ST_OK;
		end else if (step) begin
			phase_q      <= phase_n;
			bif_q        <= bif_n;
			acc_q        <= acc_n;
			cnt_q        <= cnt_n;
			ns_left_q    <= ns_left_n;
			ns_ctr_q     <= ns_ctr_n;
			bytes_left_q <= bytes_left_n;
			opt_left_q   <= opt_left_n;
			err_q        <= err_n;
		end
	end

endmodule

// ----- rtl/cdp_out_stage.sv -----
// result register driving the output channel
module cdp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cdp_pkg::res_t     result,
	output logic              busy,
	cdp_out_if.source         res
);

	logic          vld_q;
	cdp_pkg::res_t res_q;

	// valid flag: loaded on a processed item, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= result.vld;
		end else if (res.ready) begin
			vld_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load && result.vld) begin
			res_q <= result;
		end
	end

	assign busy                 = vld_q & ~res.ready;
	assign res.valid            = vld_q;
	assign res.result_kind      = res_q.result_kind;
	assign res.field_id         = res_q.field_id;
	assign res.field_value      = res_q.field_value;
	assign res.namespace_number = res_q.namespace_number;
	assign res.end_of_document  = res_q.end_of_document;
	assign res.status           = res_q.status;

endmodule

// ----- rtl/capability_document_parser.sv -----
// capability document parser: byte-serial parse of a binary capability document
// path: an accepted byte is held in the input register, then parsed, and its result is loaded into the result register
// throughput: one byte per cycle; a byte waits in the input register only while
//   the result register holds an item that is not taken
// reset: asynchronous, clears parse state and valid flags, limit goes to 4096
module capability_document_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	cdp_in_if.sink      doc,
	cdp_out_if.source   res
);

	logic          v_s1;
	logic [7:0]    data_s1;
	logic          last_s1;
	logic          busy;
	logic          advance;
	cdp_pkg::res_t result;

	// a registered byte moves on whenever the result register is free
	assign advance   = v_s1 & ~busy;
	assign doc.ready = ~v_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (doc.ready) begin
			v_s1 <= doc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (doc.ready && doc.valid) begin
			data_s1 <= doc.data_byte;
			last_s1 <= doc.last_byte;
		end
	end

	cdp_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (advance),
		.data_byte   (data_s1),
		.last_byte   (last_s1),
		.result      (result)
	);

	cdp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.result (result),
		.busy   (busy),
		.res    (res)
	);

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the capability document parser
module tb_top;

	// own field ids for the directed rows
	localparam logic [3:0] FID_PMIN   = 4'd0;
	localparam logic [3:0] FID_PMAX   = 4'd1;
	localparam logic [3:0] FID_MAXOBJ = 4'd4;

	// byte sizes of header fields pmin .. security, nscount, optcount
	localparam int unsigned FIELD_BYTES [10] = '{1, 1, 2, 4, 8, 1, 1, 2, 1, 2};
	localparam int unsigned OPT_HDR_BYTES = 3;
	localparam int unsigned HDR_BYTES = 20;
	localparam logic [cdp_pkg::LENGTH_COUNTER_BITS-1:0] COUNT_SAT = '1;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 64;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  fid;
		logic [63:0] value;
		logic [7:0]  ns;
		logic        eod;
		logic [2:0]  status;
	} parse_result_t;

	typedef struct packed {
		logic [7:0]    b;
		logic          lst;
		logic          known;
		parse_result_t want;
	} doc_row_t;

	typedef enum int unsigned {
		SHAPE_WELL, SHAPE_CUT, SHAPE_TRAIL, SHAPE_BADVER, SHAPE_NOISE, SHAPE_WIDE
	} doc_shape_t;

	localparam parse_result_t NO_RESULT = '0;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	cdp_in_if  doc_if ();
	cdp_out_if res_if ();

	capability_document_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.doc(doc_if),
		.res(res_if)
	);

	// predictor copy of the parser state
	logic [15:0]                             limit_model = cdp_pkg::MAX_LEN_RESET;
	logic [3:0]                              cur_phase = cdp_pkg::PH_VERSION;
	logic [2:0]                              field_byte_idx = '0;
	logic [63:0]                             field_acc = '0;
	logic [cdp_pkg::LENGTH_COUNTER_BITS-1:0] byte_count = '0;
	logic [7:0]                              ns_remaining = '0;
	logic [7:0]                              ns_index = '0;
	logic [15:0]                             run_left = '0;
	logic [15:0]                             opts_remaining = '0;
	logic [2:0]                              doc_error = cdp_pkg::ST_OK;

	parse_result_t parse_results_due [$];
	logic [7:0]    doc_bytes [$];

	int unsigned in_gap_pct = 19;
	int unsigned out_stall_pct = 19;
	int unsigned holds_asked = 0;
	int unsigned holds_done = 0;
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned bytes_sent = 0;
	int unsigned docs_sent = 0;
	int unsigned status_tally [5] = '{0, 0, 0, 0, 0};
	int unsigned quiet_cycles = 0;

	// directed opening: error statuses, then one full document with extreme values
	doc_row_t opening_rows [27] = '{
		'{8'h00, 1'b1, 1'b1,
			'{cdp_pkg::KIND_STATUS, 4'd0, 64'd0, 8'd0, 1'b1, cdp_pkg::ST_BADVER}},
		'{8'hFF, 1'b1, 1'b1,
			'{cdp_pkg::KIND_STATUS, 4'd0, 64'd0, 8'd0, 1'b1, cdp_pkg::ST_BADVER}},
		'{8'h01, 1'b1, 1'b1,
			'{cdp_pkg::KIND_STATUS, 4'd0, 64'd0, 8'd0, 1'b1, cdp_pkg::ST_TRUNC}},
		'{8'h01, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b1,
			'{cdp_pkg::KIND_FIELD, FID_PMIN, 64'hFF, 8'd0, 1'b0, cdp_pkg::ST_OK}},
		'{8'h00, 1'b0, 1'b1,
			'{cdp_pkg::KIND_FIELD, FID_PMAX, 64'd0, 8'd0, 1'b0, cdp_pkg::ST_OK}},
		'{8'h34, 1'b0, 1'b0, NO_RESULT},
		'{8'h12, 1'b0, 1'b0, NO_RESULT},
		'{8'h78, 1'b0, 1'b0, NO_RESULT},
		'{8'h56, 1'b0, 1'b0, NO_RESULT},
		'{8'h34, 1'b0, 1'b0, NO_RESULT},
		'{8'h12, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b1,
			'{cdp_pkg::KIND_FIELD, FID_MAXOBJ, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b0,
			cdp_pkg::ST_OK}},
		'{8'h5A, 1'b0, 1'b0, NO_RESULT},
		'{8'hA5, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b1,
			'{cdp_pkg::KIND_FIELD, cdp_pkg::FID_NSCOUNT, 64'd0, 8'd0, 1'b0, cdp_pkg::ST_OK}},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b1, 1'b1,
			'{cdp_pkg::KIND_FIELD, cdp_pkg::FID_OPTCOUNT, 64'd0, 8'd0, 1'b1, cdp_pkg::ST_OK}}
	};

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// append one byte to the document being built
	function automatic void add_doc_byte(input logic [7:0] b);
		doc_bytes.insert(doc_bytes.size(), b);
	endfunction

	// queue one expected result item
	function automatic void expect_result(input parse_result_t r);
		parse_results_due.insert(parse_results_due.size(), r);
	endfunction

	// close one namespace and pick the next phase
	function automatic void close_namespace();
		ns_index = ns_index + 1'b1;
		ns_remaining = ns_remaining - 1'b1;
		cur_phase = (ns_remaining != 0) ? cdp_pkg::PH_NSLEN : cdp_pkg::PH_OPTCOUNT;
	endfunction

	// close one option record and pick the next phase
	function automatic void close_option();
		opts_remaining = opts_remaining - 1'b1;
		cur_phase = (opts_remaining != 0) ? cdp_pkg::PH_OPTHDR : cdp_pkg::PH_DONE;
	endfunction

	// advance the predicted parser by one byte; returns 1 when a result is due
	function automatic bit parse_doc_byte(input logic [7:0] b, input logic lst,
		output parse_result_t r);
		bit          emit;
		int unsigned id;
		int unsigned nb;
		emit = 1'b0;
		r = '{cdp_pkg::KIND_STATUS, 4'd0, 64'd0, 8'd0, 1'b0, cdp_pkg::ST_OK};

		// saturating byte count against the limit
		if (byte_count == COUNT_SAT) begin
			doc_error = cdp_pkg::ST_LONG;
		end else begin
			byte_count = byte_count + 1'b1;
			if (byte_count > limit_model) begin
				doc_error = cdp_pkg::ST_LONG;
			end
		end

		// parse only while no error is pending
		if (doc_error == cdp_pkg::ST_OK) begin
			if (cur_phase == cdp_pkg::PH_VERSION) begin
				if (b != cdp_pkg::DOC_VERSION) begin
					doc_error = cdp_pkg::ST_BADVER;
				end else begin
					cur_phase = cdp_pkg::PH_PMIN;
				end
			end else if ((cur_phase >= cdp_pkg::PH_PMIN && cur_phase <= cdp_pkg::PH_NSCOUNT) ||
				cur_phase == cdp_pkg::PH_OPTCOUNT) begin
				id = (cur_phase == cdp_pkg::PH_OPTCOUNT) ? 32'(cdp_pkg::FID_OPTCOUNT) :
					32'(cur_phase - cdp_pkg::PH_PMIN);
				field_acc = field_acc | (64'(b) << (8 * field_byte_idx));
				nb = 32'(field_byte_idx) + 1;
				if (nb >= FIELD_BYTES[id]) begin
					emit = 1'b1;
					r.kind = cdp_pkg::KIND_FIELD;
					r.fid = 4'(id);
					r.value = field_acc;
					field_acc = '0;
					field_byte_idx = '0;
					if (id <= cdp_pkg::FID_SECURITY) begin
						cur_phase = cur_phase + 1'b1;
					end else if (id == cdp_pkg::FID_NSCOUNT) begin
						ns_remaining = r.value[7:0];
						ns_index = '0;
						cur_phase = (ns_remaining != 0) ? cdp_pkg::PH_NSLEN :
							cdp_pkg::PH_OPTCOUNT;
					end else begin
						opts_remaining = r.value[15:0];
						cur_phase = (opts_remaining != 0) ? cdp_pkg::PH_OPTHDR :
							cdp_pkg::PH_DONE;
					end
				end else begin
					field_byte_idx = 3'(nb);
				end
			end else if (cur_phase == cdp_pkg::PH_NSLEN) begin
				emit = 1'b1;
				r.kind = cdp_pkg::KIND_NSLEN;
				r.value = 64'(b);
				r.ns = ns_index;
				run_left = 16'(b);
				if (b == 8'd0) begin
					close_namespace();
				end else begin
					cur_phase = cdp_pkg::PH_NSBYTE;
				end
			end else if (cur_phase == cdp_pkg::PH_NSBYTE) begin
				emit = 1'b1;
				r.kind = cdp_pkg::KIND_NSBYTE;
				r.value = 64'(b);
				r.ns = ns_index;
				run_left = run_left - 1'b1;
				if (run_left == 0) begin
					close_namespace();
				end
			end else if (cur_phase == cdp_pkg::PH_OPTHDR) begin
				// key byte is skipped, then the value length low and high
				if (field_byte_idx == 3'd1) begin
					field_acc = 64'(b);
				end else if (field_byte_idx == 3'd2) begin
					field_acc = field_acc | (64'(b) << 8);
				end
				nb = 32'(field_byte_idx) + 1;
				if (nb >= OPT_HDR_BYTES) begin
					run_left = field_acc[15:0];
					field_acc = '0;
					field_byte_idx = '0;
					if (run_left == 0) begin
						close_option();
					end else begin
						cur_phase = cdp_pkg::PH_OPTVAL;
					end
				end else begin
					field_byte_idx = 3'(nb);
				end
			end else if (cur_phase == cdp_pkg::PH_OPTVAL) begin
				run_left = run_left - 1'b1;
				if (run_left == 0) begin
					close_option();
				end
			end else begin
				doc_error = cdp_pkg::ST_TRAIL;
			end
		end

		if (!emit && !lst) begin
			return 1'b0;
		end

		// last byte carries the document status and restarts the parse
		if (lst) begin
			r.eod = 1'b1;
			if (doc_error != cdp_pkg::ST_OK) begin
				r.status = doc_error;
			end else if (cur_phase != cdp_pkg::PH_DONE) begin
				r.status = cdp_pkg::ST_TRUNC;
			end else begin
				r.status = cdp_pkg::ST_OK;
			end
			cur_phase = cdp_pkg::PH_VERSION;
			field_byte_idx = '0;
			field_acc = '0;
			byte_count = '0;
			ns_remaining = '0;
			ns_index = '0;
			run_left = '0;
			opts_remaining = '0;
			doc_error = cdp_pkg::ST_OK;
		end
		return 1'b1;
	endfunction

	// random byte leaning toward the extremes
	function automatic logic [7:0] rand_byte();
		int unsigned roll;
		roll = $urandom_range(7);
		if (roll == 0) begin
			return 8'h00;
		end
		if (roll == 1) begin
			return 8'hFF;
		end
		return 8'($urandom);
	endfunction

	// build one document of the given shape into doc_bytes
	function automatic void make_doc(input doc_shape_t shape);
		int unsigned n_ns;
		int unsigned n_opt;
		int unsigned len;
		int unsigned keep;
		logic [7:0]  first;
		doc_bytes.delete();
		if (shape == SHAPE_NOISE) begin
			len = $urandom_range(1, 30);
			repeat (len) add_doc_byte(rand_byte());
			return;
		end
		add_doc_byte(cdp_pkg::DOC_VERSION);
		repeat (HDR_BYTES) add_doc_byte(rand_byte());

		// namespaces, mostly empty ones in a wide document
		n_ns = (shape == SHAPE_WIDE) ? $urandom_range(200, 255) : $urandom_range(0, 3);
		add_doc_byte(8'(n_ns));
		repeat (n_ns) begin
			if (shape == SHAPE_WIDE) begin
				len = ($urandom_range(7) == 0) ? 1 : 0;
			end else begin
				len = $urandom_range(0, 5);
			end
			add_doc_byte(8'(len));
			repeat (len) add_doc_byte(rand_byte());
		end

		// option records
		n_opt = $urandom_range(0, 3);
		add_doc_byte(8'(n_opt));
		add_doc_byte(8'h00);
		repeat (n_opt) begin
			len = $urandom_range(0, 5);
			add_doc_byte(rand_byte());
			add_doc_byte(8'(len));
			add_doc_byte(8'h00);
			repeat (len) add_doc_byte(rand_byte());
		end

		// defects
		case (shape)
			SHAPE_TRAIL: begin
				repeat ($urandom_range(1, 3)) add_doc_byte(rand_byte());
			end
			SHAPE_CUT: begin
				keep = $urandom_range(1, doc_bytes.size() - 1);
				while (doc_bytes.size() > keep) void'(doc_bytes.pop_back());
			end
			SHAPE_BADVER: begin
				first = rand_byte();
				doc_bytes[0] = (first == cdp_pkg::DOC_VERSION) ? 8'h81 : first;
				keep = $urandom_range(1, 6);
				while (doc_bytes.size() > keep) void'(doc_bytes.pop_back());
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void note_mismatch(input string what, input parse_result_t want,
		input parse_result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t %s: want kind %0d id %0d value %h ns %0d eod %0b status %0d",
				$time, what, want.kind, want.fid, want.value, want.ns, want.eod, want.status);
			$display("    got kind %0d id %0d value %h ns %0d eod %0b status %0d",
				got.kind, got.fid, got.value, got.ns, got.eod, got.status);
		end
	endfunction

	// offer one byte, wait for acceptance, queue what it should produce
	task automatic feed_byte(input logic [7:0] b, input logic lst, input logic known,
		input parse_result_t want);
		parse_result_t pred;
		bit            emitted;
		while ($urandom_range(99) < in_gap_pct) begin
			doc_if.valid <= 1'b0;
			@(negedge clk);
		end
		doc_if.valid <= 1'b1;
		doc_if.data_byte <= b;
		doc_if.last_byte <= lst;
		@(posedge clk);
		while (!doc_if.ready) @(posedge clk);
		emitted = parse_doc_byte(b, lst, pred);
		if (known) begin
			expect_result(want);
		end else if (emitted) begin
			expect_result(pred);
		end
		bytes_sent++;
		if (lst) begin
			docs_sent++;
		end
		@(negedge clk);
	endtask

	task automatic send_doc();
		foreach (doc_bytes[k]) begin
			feed_byte(doc_bytes[k], k == doc_bytes.size() - 1, 1'b0, NO_RESULT);
		end
	endtask

	// random documents until the byte budget is used
	task automatic send_docs(input int unsigned budget);
		int unsigned start;
		int unsigned roll;
		doc_shape_t  shape;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			roll = $urandom_range(99);
			if (roll < 62) begin
				shape = SHAPE_WELL;
			end else if (roll < 76) begin
				shape = SHAPE_CUT;
			end else if (roll < 86) begin
				shape = SHAPE_TRAIL;
			end else if (roll < 94) begin
				shape = SHAPE_BADVER;
			end else begin
				shape = SHAPE_NOISE;
			end
			make_doc(shape);
			send_doc();
		end
	endtask

	// drain, let the pipeline settle, then write the length limit
	task automatic set_doc_limit(input logic [15:0] lim);
		doc_if.valid <= 1'b0;
		while (parse_results_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_data <= lim;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		limit_model = lim;
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				holds_done++;
			end else begin
				res_if.ready <= ($urandom_range(99) >= out_stall_pct);
			end
		end
	end

	// compare each result item with the oldest prediction
	always @(posedge clk) begin : result_check
		parse_result_t got;
		parse_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = '{res_if.result_kind, res_if.field_id, res_if.field_value,
				res_if.namespace_number, res_if.end_of_document, res_if.status};
			results_seen++;
			if (got.eod && got.status <= cdp_pkg::ST_LONG) begin
				status_tally[got.status]++;
			end
			if (parse_results_due.size() == 0) begin
				note_mismatch("result with none expected", NO_RESULT, got);
			end else begin
				want = parse_results_due.pop_front();
				if (got.kind !== want.kind || got.fid !== want.fid ||
					got.value !== want.value || got.ns !== want.ns ||
					got.eod !== want.eod || got.status !== want.status) begin
					note_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if (!arst_n || (doc_if.valid && doc_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		doc_if.valid = 1'b0;
		doc_if.data_byte = '0;
		doc_if.last_byte = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows at the reset limit
		foreach (opening_rows[i]) begin
			feed_byte(opening_rows[i].b, opening_rows[i].lst, opening_rows[i].known,
				opening_rows[i].want);
		end

		// widest limit: a stretch with no idling, then a wide document under a long hold
		set_doc_limit(16'hFFFF);
		in_gap_pct = 0;
		out_stall_pct = 0;
		send_docs(40);
		in_gap_pct = 19;
		out_stall_pct = 19;
		holds_asked++;
		make_doc(SHAPE_WIDE);
		send_doc();
		send_docs(20);

		// smallest limits: almost every document is too long
		set_doc_limit(16'd1);
		send_docs(8);
		set_doc_limit(16'd0);
		send_docs(4);

		// limits near typical document sizes
		set_doc_limit(16'd40);
		send_docs(20);
		set_doc_limit(16'($urandom_range(24, 600)));
		send_docs(20);

		// back to the reset value
		set_doc_limit(cdp_pkg::MAX_LEN_RESET);
		send_docs(20);

		doc_if.valid <= 1'b0;
		while (parse_results_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("run: %0d documents, %0d bytes, %0d results checked, limits 0 to 65535",
			docs_sent, bytes_sent, results_seen);
		$display("end status: ok %0d, bad version %0d, truncated %0d, trailing %0d, long %0d",
			status_tally[cdp_pkg::ST_OK], status_tally[cdp_pkg::ST_BADVER],
			status_tally[cdp_pkg::ST_TRUNC], status_tally[cdp_pkg::ST_TRAIL],
			status_tally[cdp_pkg::ST_LONG]);
		if (mismatches == 0 && parse_results_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
